[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the vertex normal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define HVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define HVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hvn_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, types and helpers of the heightmap vertex normal block.
package hvn_pkg;

  localparam int HEIGHT_W = 8;
  localparam int SUM_W    = 11;
  localparam int MAG_W    = 10;
  localparam int SQ_W     = 20;
  localparam int LEN_W    = 22;
  localparam int QUO_W    = 31;
  localparam int ROOT_W   = 16;
  localparam int CFG_DW   = 13;
  localparam int CFG_IW   = 2;
  localparam int GW_W     = 9;
  localparam int GH_W     = 13;
  localparam int DIV_W    = 8;
  localparam int NX_W     = 16;
  localparam int NY_W     = 15;
  localparam int VCOL_W   = 8;
  localparam int VROW_W   = 12;

  typedef enum logic [CFG_IW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_DIVISOR     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   sq;
    logic [LEN_W-1:0]  len2;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } unit_rsp_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    slot_inc = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    slot_add = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

endpackage

[rtl/hvn_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: height samples, normal results and register writes.
interface hvn_height_if;
  logic                         valid;
  logic                         ready;
  logic [hvn_pkg::HEIGHT_W-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hvn_normal_if;
  logic                              valid;
  logic                              ready;
  logic signed [hvn_pkg::NX_W-1:0]   normal_x;
  logic [hvn_pkg::NY_W-1:0]          normal_y;
  logic signed [hvn_pkg::NX_W-1:0]   normal_z;
  logic [hvn_pkg::VCOL_W-1:0]        vertex_col;
  logic [hvn_pkg::VROW_W-1:0]        vertex_row;
  logic                              last_of_run;
  logic                              frame_done;
  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output vertex_col, output vertex_row, output last_of_run,
                  output frame_done, input ready);
  modport sink (input valid, input normal_x, input normal_y, input normal_z,
                input vertex_col, input vertex_row, input last_of_run,
                input frame_done, output ready);
endinterface

interface hvn_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hvn_pkg::CFG_IW-1:0] index;
  logic [hvn_pkg::CFG_DW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/hvn_unit_len.sv]
`timescale 1ns / 1ps
// Bit-serial divider and square root giving one Q1.15 unit-vector magnitude.
module hvn_unit_len (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hvn_pkg::unit_req_t req_i,
  output hvn_pkg::unit_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_DIV  = 3'b010,
    U_SQRT = 3'b100
  } ustate_e;

  ustate_e                      state_q;
  logic [4:0]                   cnt_q;
  logic [hvn_pkg::LEN_W-1:0]    rem_q;
  logic [hvn_pkg::LEN_W-1:0]    den_q;
  logic [hvn_pkg::QUO_W-1:0]    quo_q;
  logic [hvn_pkg::QUO_W-1:0]    v_q;
  logic [hvn_pkg::QUO_W-1:0]    r_q;
  logic [hvn_pkg::QUO_W-1:0]    bit_q;
  logic                         done_q;
  logic [hvn_pkg::ROOT_W-1:0]   root_q;

  logic [hvn_pkg::LEN_W:0]      trial;
  logic                         ge;
  logic [hvn_pkg::QUO_W-1:0]    quo_d;
  logic [hvn_pkg::QUO_W:0]      sum;
  logic                         take;
  logic [hvn_pkg::QUO_W-1:0]    r_d;

  always_comb begin
    trial = (cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = trial >= {1'b0, den_q};
    quo_d = {quo_q[hvn_pkg::QUO_W-2:0], ge};
    sum   = {1'b0, r_q} + {1'b0, bit_q};
    take  = {1'b0, v_q} >= sum;
    r_d   = take ? (r_q >> 1) + bit_q : (r_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == U_SQRT) && (cnt_q == 5'd15);
      case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            state_q <= U_DIV;
            cnt_q   <= '0;
          end
        end
        U_DIV: begin
          if (cnt_q == 5'd30) begin
            state_q <= U_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        U_SQRT: begin
          if (cnt_q == 5'd15) begin
            state_q <= U_IDLE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          rem_q <= hvn_pkg::LEN_W'(req_i.sq);
          den_q <= (req_i.len2 == '0) ? hvn_pkg::LEN_W'(1) : req_i.len2;
          quo_q <= '0;
        end
      end
      U_DIV: begin
        rem_q <= ge ? hvn_pkg::LEN_W'(trial - {1'b0, den_q}) : trial[hvn_pkg::LEN_W-1:0];
        quo_q <= quo_d;
        if (cnt_q == 5'd30) begin
          v_q   <= quo_d;
          r_q   <= '0;
          bit_q <= hvn_pkg::QUO_W'(1) << (hvn_pkg::QUO_W - 1);
        end
      end
      U_SQRT: begin
        if (take) begin
          v_q <= hvn_pkg::QUO_W'({1'b0, v_q} - sum);
        end
        r_q    <= r_d;
        bit_q  <= bit_q >> 2;
        root_q <= hvn_pkg::ROOT_W'(r_d);
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

[rtl/heightmap_vertex_normals.sv]
`timescale 1ns / 1ps
// Top level: line store, vertex sequencer and normal output register.
//
//  channel   | dir | beat
//  cfg_i     | in  | register index, write data
//  height_i  | in  | one raw height sample, raster order
//  normal_o  | out | unit normal, vertex position, run and frame flags
//
// One result takes nine line-store reads, one sum, a squaring of each component, then per
// component a launch, 31 divide steps, 16 root steps and a done strobe, then the output load.
// Row 0 samples are only stored; each later one yields one result, two on the last row.
// No clearing pass after reset; every height that enters a sum was written in this frame.
// A finished result waits in the output register while the next sample is taken.
`include "assert_macros.svh"
module heightmap_vertex_normals #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hvn_cfg_if.sink      cfg_i,
  hvn_height_if.sink   height_i,
  hvn_normal_if.source normal_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_READ   = 7'b000_0010,
    ST_ACC    = 7'b000_0100,
    ST_SQ     = 7'b000_1000,
    ST_LAUNCH = 7'b001_0000,
    ST_WAIT   = 7'b010_0000,
    ST_OUT    = 7'b100_0000
  } state_e;

  state_e state_q;

  logic [hvn_pkg::GW_W-1:0]  grid_width_q;
  logic [hvn_pkg::GH_W-1:0]  grid_height_q;
  logic [hvn_pkg::DIV_W-1:0] divisor_q;
  logic [CW-1:0]             last_col;
  logic [RW-1:0]             last_row;
  logic [hvn_pkg::DIV_W-1:0] dval;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [1:0]    slot_q;

  logic [CW-1:0] vc_q;
  logic [RW-1:0] vr_q;
  logic [1:0]    sb_q;
  logic          pend2_q;

  logic [hvn_pkg::HEIGHT_W-1:0] mem_q [DEPTH];
  logic [hvn_pkg::HEIGHT_W-1:0] rd_data_q;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;

  logic [1:0] rd_ro_q, rd_co_q, cap_ro_q, cap_co_q;
  logic       rd_vld_q, rd_done_q;
  logic [hvn_pkg::HEIGHT_W-1:0] win_q [3][3];
  logic [CW:0]   colx;
  logic [CW-1:0] colsel;
  logic [1:0]    rslot;

  logic [1:0] col_ok, row_ok;
  logic signed [hvn_pkg::SUM_W-1:0] sx_d, sz_d, sx_q, sz_q;
  logic [hvn_pkg::SUM_W-1:0]        sy_d, sy_q;

  logic [1:0]                 comp_q;
  logic signed [hvn_pkg::SUM_W-1:0] csel;
  logic [hvn_pkg::MAG_W-1:0]  mag;
  logic [hvn_pkg::SQ_W-1:0]   sq;
  logic [hvn_pkg::SQ_W-1:0]   sq_q [3];
  logic [hvn_pkg::LEN_W-1:0]  len2_q;
  logic                       neg;
  logic [hvn_pkg::ROOT_W-1:0] rmin;
  logic [hvn_pkg::NX_W-1:0]   qval;
  logic [hvn_pkg::NX_W-1:0]   nx_q, nz_q;
  logic [hvn_pkg::NY_W-1:0]   ny_q;

  hvn_pkg::unit_req_t req;
  hvn_pkg::unit_rsp_t rsp;

  logic in_fire, cfg_fire, out_load, out_valid_q;

  always_comb begin
    if (grid_width_q < hvn_pkg::GW_W'(2)) begin
      last_col = CW'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(grid_width_q - hvn_pkg::GW_W'(1));
    end
    if (grid_height_q < hvn_pkg::GH_W'(2)) begin
      last_row = RW'(1);
    end else if (32'(grid_height_q) > MAX_HEIGHT) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(grid_height_q - hvn_pkg::GH_W'(1));
    end
    dval = (divisor_q == '0) ? hvn_pkg::DIV_W'(1) : divisor_q;
  end

  assign cfg_i.ready    = 1'b1;
  assign cfg_fire       = cfg_i.valid && cfg_i.ready;
  assign height_i.ready = (state_q == ST_IDLE);
  assign in_fire        = height_i.valid && height_i.ready;
  assign out_load       = (state_q == ST_OUT) && (!out_valid_q || normal_o.ready);

  // line store
  always_comb begin
    waddr  = AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q));
    rslot  = hvn_pkg::slot_add(sb_q, rd_ro_q);
    colx   = {1'b0, vc_q} + (CW + 1)'(rd_co_q) - (CW + 1)'(1);
    colsel = ((vc_q == '0 && rd_co_q == 2'd0) || colx > {1'b0, last_col}) ? '0 : colx[CW-1:0];
    raddr  = AW'(32'(rslot) * MAX_WIDTH + 32'(colsel));
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_q[waddr] <= height_i.height;
    end
    rd_data_q <= mem_q[raddr];
  end

  // face normal sums over the up to four touching cells
  always_comb begin
    col_ok[0] = (vc_q != '0);
    col_ok[1] = (vc_q != last_col);
    row_ok[0] = (vr_q != '0);
    row_ok[1] = (vr_q != last_row);
    sx_d = '0;
    sy_d = '0;
    sz_d = '0;
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        if (col_ok[i] && row_ok[j]) begin
          sx_d = sx_d + $signed({3'b000, win_q[j][i]}) - $signed({3'b000, win_q[j][i+1]});
          sz_d = sz_d + $signed({3'b000, win_q[j][i]}) - $signed({3'b000, win_q[j+1][i]});
          sy_d = sy_d + {3'b000, dval};
        end
      end
    end
  end

  always_comb begin
    case (comp_q)
      2'd0:    csel = sx_q;
      2'd1:    csel = $signed(sy_q);
      default: csel = sz_q;
    endcase
    mag  = csel[hvn_pkg::SUM_W-1] ? hvn_pkg::MAG_W'(-csel) : hvn_pkg::MAG_W'(csel);
    sq   = hvn_pkg::SQ_W'(mag) * hvn_pkg::SQ_W'(mag);
    neg  = (comp_q != 2'd1) && csel[hvn_pkg::SUM_W-1];
    if (neg) begin
      rmin = (rsp.root > 16'h8000) ? 16'h8000 : rsp.root;
      qval = hvn_pkg::NX_W'(16'd0 - rmin);
    end else begin
      rmin = (rsp.root > 16'h7FFF) ? 16'h7FFF : rsp.root;
      qval = rmin;
    end
  end

  assign req.start = (state_q == ST_LAUNCH);
  assign req.sq    = sq_q[comp_q];
  assign req.len2  = len2_q;

  hvn_unit_len u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      grid_width_q  <= hvn_pkg::GW_W'(256);
      grid_height_q <= hvn_pkg::GH_W'(256);
      divisor_q     <= hvn_pkg::DIV_W'(15);
      col_q         <= '0;
      row_q         <= '0;
      slot_q        <= '0;
      pend2_q       <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_done_q     <= 1'b0;
      rd_ro_q       <= '0;
      rd_co_q       <= '0;
      comp_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (normal_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_i.index)
          hvn_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_i.data[hvn_pkg::GW_W-1:0];
          hvn_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_i.data[hvn_pkg::GH_W-1:0];
          hvn_pkg::CFG_DIVISOR:     divisor_q     <= cfg_i.data[hvn_pkg::DIV_W-1:0];
          default: ;
        endcase
      end
      if (cfg_fire && cfg_i.index <= hvn_pkg::CFG_DIVISOR) begin
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (in_fire) begin
        if (col_q == last_col) begin
          col_q <= '0;
          if (row_q == last_row) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + RW'(1);
            slot_q <= hvn_pkg::slot_inc(slot_q);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      rd_vld_q <= (state_q == ST_READ) && !rd_done_q;
      case (state_q)
        ST_IDLE: begin
          if (in_fire && row_q != '0) begin
            pend2_q   <= (row_q == last_row);
            rd_done_q <= 1'b0;
            rd_ro_q   <= '0;
            rd_co_q   <= '0;
            state_q   <= ST_READ;
          end
        end
        ST_READ: begin
          if (!rd_done_q) begin
            if (rd_co_q == 2'd2) begin
              rd_co_q <= '0;
              if (rd_ro_q == 2'd2) begin
                rd_done_q <= 1'b1;
              end else begin
                rd_ro_q <= rd_ro_q + 2'd1;
              end
            end else begin
              rd_co_q <= rd_co_q + 2'd1;
            end
          end
          if (rd_vld_q && cap_ro_q == 2'd2 && cap_co_q == 2'd2) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          comp_q  <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            state_q <= ST_LAUNCH;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_LAUNCH: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (rsp.done) begin
            if (comp_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= ST_LAUNCH;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (pend2_q) begin
              pend2_q   <= 1'b0;
              rd_done_q <= 1'b0;
              rd_ro_q   <= '0;
              rd_co_q   <= '0;
              state_q   <= ST_READ;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cap_ro_q <= rd_ro_q;
    cap_co_q <= rd_co_q;
    if (state_q == ST_READ && rd_vld_q) begin
      win_q[cap_ro_q][cap_co_q] <= rd_data_q;
    end
    if (state_q == ST_IDLE && in_fire) begin
      vc_q <= col_q;
      vr_q <= row_q - RW'(1);
      sb_q <= hvn_pkg::slot_inc(slot_q);
    end
    if (out_load && pend2_q) begin
      vr_q <= vr_q + RW'(1);
      sb_q <= hvn_pkg::slot_inc(sb_q);
    end
    if (state_q == ST_ACC) begin
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      sz_q   <= sz_d;
      len2_q <= '0;
    end
    if (state_q == ST_SQ) begin
      sq_q[comp_q] <= sq;
      len2_q       <= len2_q + hvn_pkg::LEN_W'(sq);
    end
    if (state_q == ST_WAIT && rsp.done) begin
      case (comp_q)
        2'd0:    nx_q <= qval;
        2'd1:    ny_q <= hvn_pkg::NY_W'(qval);
        default: nz_q <= qval;
      endcase
    end
    if (out_load) begin
      normal_o.normal_x    <= $signed(nx_q);
      normal_o.normal_y    <= ny_q;
      normal_o.normal_z    <= $signed(nz_q);
      normal_o.vertex_col  <= hvn_pkg::VCOL_W'(vc_q);
      normal_o.vertex_row  <= hvn_pkg::VROW_W'(vr_q);
      normal_o.last_of_run <= !pend2_q;
      normal_o.frame_done  <= (vc_q == last_col) && (vr_q == last_row);
    end
  end

  assign normal_o.valid = out_valid_q;

  `HVN_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result without sequencer")
  `HVN_ASSERT(a_frame_last, (out_valid_q && normal_o.frame_done) |-> normal_o.last_of_run, "frame end not last of run")
  `HVN_ASSERT_NEXT(a_second_vertex, out_load && pend2_q, state_q == ST_READ && !pend2_q, "second vertex not started")
  `HVN_ASSERT(a_pos_range, (col_q <= last_col) && (row_q <= last_row), "position beyond grid")

endmodule

[tb/hvn_normal_checker.sv]
`timescale 1ns / 1ps
// Checker for the vertex normal block: predicts each normal beat and compares it.
module hvn_normal_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  hvn_cfg_if     cfg_i,
  hvn_height_if  height_i,
  hvn_normal_if  normal_i,
  output int     fail_count_o,
  output int     pending_o
);

  localparam int GRID_MAX_W = 256;
  localparam int GRID_MAX_H = 4096;

  typedef struct packed {
    logic signed [hvn_pkg::NX_W-1:0] nx;
    logic [hvn_pkg::NY_W-1:0]        ny;
    logic signed [hvn_pkg::NX_W-1:0] nz;
    logic [hvn_pkg::VCOL_W-1:0]      vcol;
    logic [hvn_pkg::VROW_W-1:0]      vrow;
    logic                            last;
    logic                            frame_end;
  } normal_beat_t;

  normal_beat_t              normals_due[$];
  logic [7:0]                line_mem[3][GRID_MAX_W];
  logic [hvn_pkg::GW_W-1:0]  width_reg;
  logic [hvn_pkg::GH_W-1:0]  height_reg;
  logic [hvn_pkg::DIV_W-1:0] divisor_reg;
  int unsigned               next_col;
  int unsigned               next_row;
  int                        fails;
  int                        pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > GRID_MAX_W) return GRID_MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > GRID_MAX_H) return GRID_MAX_H;
    return height_reg;
  endfunction

  function automatic int sample_at(int unsigned col, int unsigned row);
    return int'(line_mem[row % 3][col % GRID_MAX_W]);
  endfunction

  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] probe;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] unit_component(int s, longint unsigned len2);
    longint unsigned mag;
    longint unsigned ratio;
    logic [31:0]     q;
    mag   = (s < 0) ? longint'(-s) : longint'(s);
    ratio = ((mag * mag) << 30) / len2;
    if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    q = int_root(ratio[31:0]);
    if (s < 0) begin
      if (q > 32768) q = 32768;
      return 16'(32'h1_0000 - q);
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic normal_beat_t vertex_normal(int unsigned vc, int unsigned vr,
                                                 int unsigned w, int unsigned h);
    normal_beat_t    nb;
    int              sx, sy, sz, d;
    int unsigned     a, b;
    longint unsigned len2;
    logic [15:0]     ycomp;
    sx = 0;
    sy = 0;
    sz = 0;
    d  = (divisor_reg == 0) ? 1 : int'(divisor_reg);
    for (int k = 0; k < 4; k++) begin
      if (vc + (k & 1) >= 1 && vr + (k >> 1) >= 1) begin
        a = vc + (k & 1) - 1;
        b = vr + (k >> 1) - 1;
        if (a < w - 1 && b < h - 1) begin
          sx += sample_at(a, b) - sample_at(a + 1, b);
          sy += d;
          sz += sample_at(a, b) - sample_at(a, b + 1);
        end
      end
    end
    len2 = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
    if (len2 == 0) len2 = 1;
    ycomp        = unit_component(sy, len2);
    nb.nx        = unit_component(sx, len2);
    nb.ny        = ycomp[hvn_pkg::NY_W-1:0];
    nb.nz        = unit_component(sz, len2);
    nb.vcol      = hvn_pkg::VCOL_W'(vc);
    nb.vrow      = hvn_pkg::VROW_W'(vr);
    nb.last      = 1'b0;
    nb.frame_end = (vc == w - 1 && vr == h - 1);
    return nb;
  endfunction

  task automatic predict_sample(logic [7:0] sample);
    int unsigned  w, h, c, r;
    normal_beat_t nb[2];
    int           n;
    w = eff_width();
    h = eff_height();
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    n = 0;
    line_mem[r % 3][c] = sample;
    if (r >= 1) begin
      nb[n] = vertex_normal(c, r - 1, w, h);
      n++;
    end
    if (r == h - 1) begin
      nb[n] = vertex_normal(c, r, w, h);
      n++;
    end
    if (n > 0) nb[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) normals_due.push_back(nb[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    normal_beat_t got, want;
    if (!rst_ni) begin
      width_reg   = 9'd256;
      height_reg  = 13'd256;
      divisor_reg = 8'd15;
      next_col    = 0;
      next_row    = 0;
      fails       = 0;
      normals_due.delete();
      pending     = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          hvn_pkg::CFG_GRID_WIDTH:  width_reg   = cfg_i.data[hvn_pkg::GW_W-1:0];
          hvn_pkg::CFG_GRID_HEIGHT: height_reg  = cfg_i.data[hvn_pkg::GH_W-1:0];
          hvn_pkg::CFG_DIVISOR:     divisor_reg = cfg_i.data[hvn_pkg::DIV_W-1:0];
          default: ;
        endcase
        if (cfg_i.index inside {hvn_pkg::CFG_GRID_WIDTH, hvn_pkg::CFG_GRID_HEIGHT,
                                hvn_pkg::CFG_DIVISOR}) begin
          next_col = 0;
          next_row = 0;
        end
      end
      if (height_i.valid && height_i.ready) predict_sample(height_i.height);
      if (normal_i.valid && normal_i.ready) begin
        got = '{normal_i.normal_x, normal_i.normal_y, normal_i.normal_z,
                normal_i.vertex_col, normal_i.vertex_row, normal_i.last_of_run,
                normal_i.frame_done};
        if (normals_due.size() == 0) begin
          fails = fails + 1;
          if (fails <= 10) $display("unexpected normal beat: expected none, got %p", got);
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            fails = fails + 1;
            if (fails <= 10) $display("normal mismatch: expected %p, got %p", want, got);
          end
        end
      end
      pending = normals_due.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives samples and register writes, stalls the output, gives the verdict.
module tb;

  localparam logic [hvn_pkg::CFG_IW-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hvn_cfg_if    cfg_bus();
  hvn_height_if height_bus();
  hvn_normal_if normal_bus();

  int fail_count;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int samples_sent = 0;
  int quiet_cycles = 0;
  logic long_hold = 1'b0;
  event hold_go;

  always #5 clk_i = ~clk_i;

  heightmap_vertex_normals uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .height_i (height_bus),
    .normal_o (normal_bus)
  );

  hvn_normal_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .height_i     (height_bus),
    .normal_i     (normal_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    normal_bus.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
  end

  always begin
    @(hold_go);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((cfg_bus.valid && cfg_bus.ready) || (height_bus.valid && height_bus.ready) ||
        (normal_bus.valid && normal_bus.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic [7:0] sample);
    if ($urandom_range(99) < gap_pct) begin
      height_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    height_bus.valid  <= 1'b1;
    height_bus.height <= sample;
    do @(posedge clk_i); while (!height_bus.ready);
    samples_sent++;
  endtask

  task automatic settle();
    height_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hvn_pkg::CFG_IW-1:0] idx,
                           logic [hvn_pkg::CFG_DW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(int w, int h, int d);
    write_reg(hvn_pkg::CFG_GRID_WIDTH, {4'($urandom), 9'(w)});
    write_reg(hvn_pkg::CFG_GRID_HEIGHT, 13'(h));
    write_reg(hvn_pkg::CFG_DIVISOR, {5'($urandom), 8'(d)});
  endtask

  task automatic send_random(int count);
    repeat (count) send_sample(8'($urandom));
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 65; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 65; end
      default: begin gap_pct = 10; stall_pct = 10; end
    endcase
  endtask

  initial begin
    int phase;
    int w, h, frames;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = hvn_pkg::CFG_GRID_WIDTH;
    cfg_bus.data      = '0;
    height_bus.valid  = 1'b0;
    height_bus.height = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // width and height below range, zero divisor, two frames of extremes
    set_grid(0, 1, 0);
    send_sample(8'd0); send_sample(8'd255); send_sample(8'd255); send_sample(8'd0);
    send_sample(8'd255); send_sample(8'd0); send_sample(8'd0); send_sample(8'd255);
    settle();
    set_grid(1, 0, 255);
    send_sample(8'd255); send_sample(8'd255); send_sample(8'd255); send_sample(8'd255);
    settle();
    // steep ramp with smallest divisor, unused index written mid-frame
    set_grid(3, 3, 1);
    send_sample(8'd0); send_sample(8'd128); send_sample(8'd255);
    send_sample(8'd0); send_sample(8'd128);
    settle();
    write_reg(CFG_UNUSED_IDX, 13'($urandom));
    send_sample(8'd255); send_sample(8'd255); send_sample(8'd0); send_sample(8'd85);
    settle();
    // height above range, partial frame
    set_grid(2, 5000, 15);
    send_random(6);
    settle();

    phase = 0;
    while (samples_sent < 1250) begin
      set_idling(phase);
      if (phase == 5) begin
        set_grid(511, 2, $urandom_range(1, 255));
        send_random(300);
      end else begin
        w = $urandom_range(2, 10);
        h = $urandom_range(2, 6);
        set_grid(w, h, $urandom_range(0, 255));
        frames = $urandom_range(1, 2);
        if (phase == 3) -> hold_go;
        if ($urandom_range(9) == 0) send_random($urandom_range(1, w * h));
        else send_random(w * h * frames);
      end
      settle();
      phase++;
    end
    set_idling(0);
    set_grid(2, 4096, 255);
    send_random(8);
    settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
